>>> rtl/hsa_pkg.sv
// Shared types and constants for the Highland scattering angle pipeline.
// No dependencies; imported by hsa_stage and highland_scatter_angle.
`default_nettype none

package hsa_pkg;

  localparam int unsigned HSA_ENERGY_FRAC_BITS = 16;
  localparam int unsigned NUM_STAGES = 133;

  // Stage schedule
  localparam int unsigned ST_CAPTURE  = 0;
  localparam int unsigned ST_PRODUCTS = 1;
  localparam int unsigned ST_ZZS      = 2;
  localparam int unsigned RDIV_FIRST  = 1;
  localparam int unsigned RDIV_LAST   = 96;
  localparam int unsigned SQRT_FIRST  = 3;
  localparam int unsigned SQRT_LAST   = 97;
  localparam int unsigned PDIV_FIRST  = 3;
  localparam int unsigned PDIV_LAST   = 34;
  localparam int unsigned ST_PV       = 35;
  localparam int unsigned ST_PV5      = 36;
  localparam int unsigned NORM1_FIRST = 3;
  localparam int unsigned NORM1_LAST  = 8;
  localparam int unsigned NORM2_FIRST = 4;
  localparam int unsigned NORM2_LAST  = 8;
  localparam int unsigned LOG_FIRST   = 9;
  localparam int unsigned LOG_LAST    = 32;
  localparam int unsigned ST_L2       = 33;
  localparam int unsigned ST_LABS     = 34;
  localparam int unsigned ST_LMUL     = 35;
  localparam int unsigned ST_LRND     = 36;
  localparam int unsigned ST_CORR     = 37;
  localparam int unsigned ST_AMUL     = 38;
  localparam int unsigned ST_PPROD    = 98;
  localparam int unsigned ST_PSUM     = 99;
  localparam int unsigned ST_QINIT    = 100;
  localparam int unsigned QDIV_FIRST  = 101;
  localparam int unsigned QDIV_LAST   = 132;

  // round(0.038 * ln2 * 2^32)
  localparam logic [26:0] LN_COEF = 27'd113127690;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_NEG     = 2'd2,
    ST_SAT     = 2'd3
  } hsa_status_e;

  typedef struct packed {
    logic               inval;
    logic [31:0]        t;
    logic [31:0]        m;
    logic [15:0]        z;
    logic [22:0]        z68;
    logic [31:0]        d;
    logic [31:0]        s;
    logic [31:0]        x0;
    logic [63:0]        tm;
    logic [32:0]        tpm;
    logic [31:0]        zz;
    logic [63:0]        zzs;
    logic [5:0]         e1;
    logic [31:0]        x2;
    logic [4:0]         e2;
    logic [31:0]        lm1;
    logic [31:0]        lm2;
    logic [23:0]        f1;
    logic [23:0]        f2;
    logic signed [31:0] l2;
    logic               lneg;
    logic [30:0]        labs;
    logic [57:0]        lmag;
    logic [26:0]        lrnd;
    logic signed [28:0] f;
    logic [50:0]        a;
    logic [31:0]        qrem;
    logic [1:0]         qbits;
    logic [47:0]        sroot;
    logic [49:0]        srem;
    logic [32:0]        prem;
    logic [31:0]        pn;
    logic [31:0]        pq;
    logic [32:0]        pv;
    logic [35:0]        d5;
    logic [50:0]        pp_hh;
    logic [50:0]        pp_hl;
    logic [47:0]        pp_lh;
    logic [47:0]        pp_ll;
    logic [98:0]        p;
    logic               sat;
    logic [35:0]        frem;
    logic [31:0]        fn;
    logic [31:0]        fq;
  } hsa_item_t;

endpackage

`default_nettype wire

>>> rtl/hsa_stage.sv
// One register stage of the scattering angle pipeline; STAGE picks its work.
// Depends on hsa_pkg.
`default_nettype none

module hsa_stage
  import hsa_pkg::*;
#(
  parameter int unsigned STAGE            = 0,
  parameter int unsigned ENERGY_FRAC_BITS = HSA_ENERGY_FRAC_BITS
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      adv_i,
  input  wire logic      vld_i,
  input  wire hsa_item_t item_i,
  output logic           vld_o,
  output hsa_item_t      item_o
);

  localparam int unsigned OUT_SHIFT = 40 - ENERGY_FRAC_BITS;
  localparam int unsigned SH1 =
      (STAGE >= NORM1_FIRST && STAGE <= NORM1_LAST) ? (32 >> (STAGE - NORM1_FIRST)) : 1;
  localparam int unsigned SH2 =
      (STAGE >= NORM2_FIRST && STAGE <= NORM2_LAST) ? (16 >> (STAGE - NORM2_FIRST)) : 1;
  localparam logic signed [28:0] F_ONE = 29'sd16777216;
  localparam logic signed [31:0] L2_BIAS = 32'sd268435456;

  hsa_item_t   item_d, item_q;
  logic        vld_q;

  logic [32:0] rq;
  logic        rq_ge;
  logic [51:0] rs;
  logic [47:0] rsh;
  logic [48:0] trial;
  logic        rs_ge;
  logic [33:0] pr;
  logic        pr_ge;
  logic [31:0] m1i, m2i;
  logic [63:0] sq1, sq2;
  logic [58:0] lsum;
  logic [98:0] full;
  logic [36:0] fr;
  logic        fr_ge;

  // radiation-length divider step
  assign rq    = {item_i.qrem, item_i.d[31]};
  assign rq_ge = rq >= {1'b0, item_i.x0};
  // square root step on the last two quotient bits
  assign rs    = {item_i.srem, item_i.qbits};
  assign rsh   = {item_i.sroot[46:0], 1'b0};
  assign trial = {rsh, 1'b1};
  assign rs_ge = rs >= {3'b0, trial};
  // pv divider step
  assign pr    = {item_i.prem, item_i.pn[31]};
  assign pr_ge = pr >= {1'b0, item_i.tpm};
  // log mantissa squaring
  assign m1i   = (STAGE == LOG_FIRST) ? item_i.zzs[63:32] : item_i.lm1;
  assign m2i   = (STAGE == LOG_FIRST) ? item_i.x2 : item_i.lm2;
  assign sq1   = m1i * m1i;
  assign sq2   = m2i * m2i;
  assign lsum  = {1'b0, item_i.lmag} + (59'd1 << 31);
  assign full  = (99'(item_i.pp_hh) << 48) + (99'(item_i.pp_hl) << 24)
               + (99'(item_i.pp_lh) << 24) + 99'(item_i.pp_ll);
  // final quotient step
  assign fr    = {item_i.frem, item_i.fn[31]};
  assign fr_ge = fr >= {1'b0, item_i.d5};

  always_comb begin
    item_d = item_i;
    if (STAGE == ST_CAPTURE) begin
      item_d.inval = (item_i.x0 == 32'd0) || (item_i.d == 32'd0) ||
                     (item_i.z == 16'd0) || (item_i.t == 32'd0);
      if (item_i.s == 32'd0) item_d.s = item_i.d;
    end
    if (STAGE == ST_PRODUCTS) begin
      item_d.tm  = item_i.t * item_i.m;
      item_d.tpm = {1'b0, item_i.t} + {1'b0, item_i.m};
      item_d.zz  = item_i.z * item_i.z;
      item_d.z68 = ({7'b0, item_i.z} << 6) + ({7'b0, item_i.z} << 2);
    end
    if (STAGE == ST_ZZS) begin
      item_d.zzs  = item_i.zz * item_i.s;
      item_d.prem = {1'b0, item_i.tm[63:32]};
      item_d.pn   = item_i.tm[31:0];
      item_d.e1   = 6'd63;
      item_d.x2   = item_i.x0;
      item_d.e2   = 5'd31;
    end
    if (STAGE >= RDIV_FIRST && STAGE <= RDIV_LAST) begin
      item_d.qrem  = rq_ge ? 32'(rq - {1'b0, item_i.x0}) : rq[31:0];
      item_d.d     = {item_i.d[30:0], 1'b0};
      item_d.qbits = {item_i.qbits[0], rq_ge};
    end
    if (STAGE >= SQRT_FIRST && STAGE <= SQRT_LAST && (STAGE % 2) == 1) begin
      if (rs_ge) begin
        item_d.srem  = 50'(rs - {3'b0, trial});
        item_d.sroot = {rsh[47:1], 1'b1};
      end else begin
        item_d.srem  = rs[49:0];
        item_d.sroot = rsh;
      end
    end
    if (STAGE >= PDIV_FIRST && STAGE <= PDIV_LAST) begin
      item_d.prem = pr_ge ? 33'(pr - {1'b0, item_i.tpm}) : pr[32:0];
      item_d.pn   = {item_i.pn[30:0], 1'b0};
      item_d.pq   = {item_i.pq[30:0], pr_ge};
    end
    if (STAGE == ST_PV) item_d.pv = {1'b0, item_i.t} + {1'b0, item_i.pq};
    if (STAGE == ST_PV5) item_d.d5 = {1'b0, item_i.pv, 2'b0} + {3'b0, item_i.pv};
    if (STAGE >= NORM1_FIRST && STAGE <= NORM1_LAST) begin
      if ((item_i.zzs >> (64 - SH1)) == 64'd0) begin
        item_d.zzs = item_i.zzs << SH1;
        item_d.e1  = item_i.e1 - 6'(SH1);
      end
    end
    if (STAGE >= NORM2_FIRST && STAGE <= NORM2_LAST) begin
      if ((item_i.x2 >> (32 - SH2)) == 32'd0) begin
        item_d.x2 = item_i.x2 << SH2;
        item_d.e2 = item_i.e2 - 5'(SH2);
      end
    end
    if (STAGE >= LOG_FIRST && STAGE <= LOG_LAST) begin
      item_d.lm1 = sq1[63] ? sq1[63:32] : sq1[62:31];
      item_d.f1  = {item_i.f1[22:0], sq1[63]};
      item_d.lm2 = sq2[63] ? sq2[63:32] : sq2[62:31];
      item_d.f2  = {item_i.f2[22:0], sq2[63]};
    end
    if (STAGE == ST_L2) begin
      item_d.l2 = $signed({2'b0, item_i.e1, item_i.f1})
                - $signed({3'b0, item_i.e2, item_i.f2}) - L2_BIAS;
    end
    if (STAGE == ST_LABS) begin
      item_d.lneg = item_i.l2[31];
      item_d.labs = item_i.l2[31] ? 31'(-item_i.l2) : item_i.l2[30:0];
    end
    if (STAGE == ST_LMUL) item_d.lmag = LN_COEF * item_i.labs;
    if (STAGE == ST_LRND) item_d.lrnd = lsum[58:32];
    if (STAGE == ST_CORR) begin
      item_d.f = item_i.lneg ? F_ONE - $signed({2'b0, item_i.lrnd})
                             : F_ONE + $signed({2'b0, item_i.lrnd});
    end
    if (STAGE == ST_AMUL) item_d.a = item_i.z68 * item_i.f[27:0];
    if (STAGE == ST_PPROD) begin
      item_d.pp_hh = item_i.a[50:24] * item_i.sroot[47:24];
      item_d.pp_hl = item_i.a[50:24] * item_i.sroot[23:0];
      item_d.pp_lh = item_i.a[23:0] * item_i.sroot[47:24];
      item_d.pp_ll = item_i.a[23:0] * item_i.sroot[23:0];
    end
    if (STAGE == ST_PSUM) item_d.p = full >> OUT_SHIFT;
    if (STAGE == ST_QINIT) begin
      item_d.sat  = item_i.p[98:32] >= {31'b0, item_i.d5};
      item_d.frem = item_i.p[67:32];
      item_d.fn   = item_i.p[31:0];
      item_d.fq   = '0;
    end
    if (STAGE >= QDIV_FIRST && STAGE <= QDIV_LAST) begin
      item_d.frem = fr_ge ? 36'(fr - {1'b0, item_i.d5}) : fr[35:0];
      item_d.fn   = {item_i.fn[30:0], 1'b0};
      item_d.fq   = {item_i.fq[30:0], fr_ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      item_q <= item_d;
    end
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule

`default_nettype wire

>>> rtl/highland_scatter_angle.sv
// Top level of the Highland multiple-scattering angle pipeline.
// Depends on hsa_pkg and hsa_stage.
//
//   channel | valid      | ready       | payload
//   --------+------------+-------------+-------------------------------------------
//   input   | in_valid_i | in_ready_o  | kinetic_energy_i .. radiation_length_i
//   output  | out_valid_o| out_ready_i | scatter_angle_o, result_status_o
//
// One request enters per cycle while the output is not stalled; each passes
// from acceptance to the output register through stage 0 (loaded at the
// accepting edge), 132 more pipeline stages, then the output register. The
// depth is set by the 96-step restoring divider for d/X0 that feeds the
// overlapped square root, followed by the 32-step final quotient.
// Reset clears only valid bits; no clearing pass is needed.
// When the output holds an untaken result, the whole pipe and the input
// freeze together, so nothing is dropped or repeated.
`default_nettype none

module highland_scatter_angle
  import hsa_pkg::*;
#(
  parameter int unsigned ENERGY_FRAC_BITS = HSA_ENERGY_FRAC_BITS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] kinetic_energy_i,
  input  wire logic [31:0] particle_mass_i,
  input  wire logic [15:0] charge_number_i,
  input  wire logic [31:0] step_thickness_i,
  input  wire logic [31:0] path_scale_i,
  input  wire logic [31:0] radiation_length_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      scatter_angle_o,
  output logic [1:0]       result_status_o
);

  localparam int unsigned LAST = NUM_STAGES - 1;

  hsa_item_t               item_in;
  hsa_item_t               stg_item [NUM_STAGES];
  logic [NUM_STAGES-1:0]   stg_vld;
  logic                    adv;

  logic                    out_valid_q;
  logic [31:0]             angle_q, angle_d;
  hsa_status_e             status_q, status_d;

  // Advance everything whenever the output register is free or being drained.
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  always_comb begin
    item_in    = '0;
    item_in.t  = kinetic_energy_i;
    item_in.m  = particle_mass_i;
    item_in.z  = charge_number_i;
    item_in.d  = step_thickness_i;
    item_in.s  = path_scale_i;
    item_in.x0 = radiation_length_i;
  end

  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
    if (g == 0) begin : g_first
      hsa_stage #(
        .STAGE            (g),
        .ENERGY_FRAC_BITS (ENERGY_FRAC_BITS)
      ) u_stage (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .adv_i  (adv),
        .vld_i  (in_valid_i),
        .item_i (item_in),
        .vld_o  (stg_vld[g]),
        .item_o (stg_item[g])
      );
    end else begin : g_rest
      hsa_stage #(
        .STAGE            (g),
        .ENERGY_FRAC_BITS (ENERGY_FRAC_BITS)
      ) u_stage (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .adv_i  (adv),
        .vld_i  (stg_vld[g-1]),
        .item_i (stg_item[g-1]),
        .vld_o  (stg_vld[g]),
        .item_o (stg_item[g])
      );
    end
  end

  // Resolve the special cases in priority order: bad input, negative
  // correction, zero correction, overflow, then the plain quotient.
  always_comb begin
    angle_d  = stg_item[LAST].fq;
    status_d = ST_OK;
    if (stg_item[LAST].inval) begin
      angle_d  = '0;
      status_d = ST_INVALID;
    end else if (stg_item[LAST].f[28]) begin
      angle_d  = '0;
      status_d = ST_NEG;
    end else if (stg_item[LAST].f == 29'sd0) begin
      angle_d  = '0;
    end else if (stg_item[LAST].sat) begin
      angle_d  = '1;
      status_d = ST_SAT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= stg_vld[LAST];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      angle_q  <= angle_d;
      status_q <= status_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign scatter_angle_o = angle_q;
  assign result_status_o = status_q;

  // A stall must freeze every valid bit in the pipe.
  a_stall_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(stg_vld))
    else $error("pipeline moved during stall");

  // An accepted request must occupy the first stage.
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> stg_vld[0])
    else $error("accepted request lost at entry");

  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_status_o == ST_SAT |-> scatter_angle_o == 32'hFFFF_FFFF)
    else $error("saturated result not all ones");

  a_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_status_o == ST_INVALID || result_status_o == ST_NEG)
      |-> scatter_angle_o == 32'd0)
    else $error("invalid or clamped result not zero");

endmodule

`default_nettype wire

>>> dv/highland_scatter_angle_tb.sv
// Self-checking testbench for highland_scatter_angle: random and directed track steps.
// Holds its own bit-exact predictor of the angle; depends on hsa_pkg and the RTL top.
`default_nettype none

module highland_scatter_angle_tb
  import hsa_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] t;
    logic [31:0] m;
    logic [15:0] z;
    logic [31:0] d;
    logic [31:0] s;
    logic [31:0] x0;
  } track_step_t;

  typedef struct packed {
    logic [31:0] angle;
    hsa_status_e status;
  } angle_result_t;

  localparam int unsigned STALL_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  track_step_t in_step = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [31:0] scatter_angle;
  logic [1:0] result_status;

  track_step_t pending_steps[$];
  angle_result_t expected_angles[$];
  bit stimulus_done = 1'b0;
  bit failed = 1'b0;
  bit step_taken = 1'b0;
  bit angle_taken = 1'b0;
  bit no_idle = 1'b0;
  int send_gap = 0;
  int recv_stall = 0;
  int idle_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  highland_scatter_angle dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .kinetic_energy_i  (in_step.t),
    .particle_mass_i   (in_step.m),
    .charge_number_i   (in_step.z),
    .step_thickness_i  (in_step.d),
    .path_scale_i      (in_step.s),
    .radiation_length_i(in_step.x0),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .scatter_angle_o   (scatter_angle),
    .result_status_o   (result_status)
  );

  // Integer square root of a 96-bit value, two bits per step.
  function automatic logic [63:0] root96(input logic [127:0] v);
    logic [127:0] rem;
    logic [63:0] root;
    logic [127:0] trial;
    rem = '0;
    root = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = (rem << 2) | ((v >> (2 * i)) & 128'd3);
      root = root << 1;
      trial = {root, 1'b1};
      if (rem >= trial) begin
        rem = rem - trial;
        root = root | 64'd1;
      end
    end
    return root;
  endfunction

  // log2 in Q.24: exponent from the leading one, fraction by repeated squaring.
  function automatic logic signed [63:0] log2_q24(input logic [63:0] x);
    int e;
    logic [63:0] mant;
    logic [63:0] frac;
    e = 63;
    while (e > 0 && !x[e]) e--;
    mant = (e >= 31) ? (x >> (e - 31)) : (x << (31 - e));
    frac = '0;
    for (int i = 0; i < 24; i++) begin
      mant = (mant * mant) >> 31;
      frac = frac << 1;
      if (mant >= 64'h1_0000_0000) begin
        mant = mant >> 1;
        frac = frac | 64'd1;
      end
    end
    return $signed((64'(e) << 24) | frac);
  endfunction

  function automatic angle_result_t highland_angle(input track_step_t st);
    angle_result_t r;
    logic [63:0] path, pv, zz, root, a;
    logic [127:0] ratio, p, q;
    logic signed [63:0] l2, prod, corr;
    logic [63:0] mag;
    r.angle = '0;
    r.status = ST_INVALID;
    if (st.x0 == 0 || st.d == 0 || st.z == 0 || st.t == 0) return r;
    path = (st.s == 0) ? 64'(st.d) : 64'(st.s);
    pv = 64'(st.t) + (64'(st.t) * 64'(st.m)) / (64'(st.t) + 64'(st.m));
    ratio = {32'd0, st.d, 64'd0} / 128'(st.x0);
    root = root96(ratio);
    zz = 64'(st.z) * 64'(st.z);
    l2 = log2_q24(zz * path) - log2_q24(64'(st.x0)) - (64'sd16 <<< 24);
    prod = $signed(64'(LN_COEF)) * l2;
    if (prod >= 0) begin
      mag = ($unsigned(prod) + 64'h8000_0000) >> 32;
      corr = (64'sd1 <<< 24) + $signed(mag);
    end else begin
      mag = ($unsigned(-prod) + 64'h8000_0000) >> 32;
      corr = (64'sd1 <<< 24) - $signed(mag);
    end
    if (corr < 0) begin
      r.status = ST_NEG;
      return r;
    end
    r.status = ST_OK;
    if (corr == 0) return r;
    a = 64'd68 * 64'(st.z) * $unsigned(corr);
    p = (128'(a) * 128'(root)) >> (40 - HSA_ENERGY_FRAC_BITS);
    q = p / (128'd5 * 128'(pv));
    if (q > 128'hFFFF_FFFF) begin
      r.angle = 32'hFFFF_FFFF;
      r.status = ST_SAT;
    end else begin
      r.angle = q[31:0];
    end
    return r;
  endfunction

  // Physical magnitudes half the time, else the full field range or a sub-unit value.
  function automatic logic [31:0] pick_q16(input int unsigned lo_int, input int unsigned hi_int);
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(1, 32'h0000_FFFF);
      default: return ($urandom_range(lo_int, hi_int) << 16) | $urandom_range(0, 16'hFFFF);
    endcase
  endfunction

  function automatic track_step_t random_step();
    track_step_t st;
    st.t = pick_q16(0, 2000);
    st.m = pick_q16(0, 1000);
    st.z = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 8 * 256));
    st.d = pick_q16(0, 20);
    st.s = ($urandom_range(0, 7) == 0) ? 32'd0 : pick_q16(0, 50);
    st.x0 = pick_q16(1, 60);
    // Occasionally break a step so the invalid path keeps getting hit.
    if ($urandom_range(0, 19) == 0) begin
      case ($urandom_range(0, 3))
        0: st.t = '0;
        1: st.z = '0;
        2: st.d = '0;
        default: st.x0 = '0;
      endcase
    end
    return st;
  endfunction

  // Fill the request queue: corners first, then random steps.
  initial begin
    track_step_t st;
    pending_steps.push_back('{32'h000A_0000, 32'h0000_8000, 16'h0100, 32'h0001_0000,
                              32'h0001_0000, 32'h0024_0000});
    pending_steps.push_back('{32'h0, 32'h0001_0000, 16'h0100, 32'h1_0000, 32'h1_0000, 32'h24_0000});
    pending_steps.push_back('{32'h1_0000, 32'h1_0000, 16'h0, 32'h1_0000, 32'h1_0000, 32'h24_0000});
    pending_steps.push_back('{32'h1_0000, 32'h1_0000, 16'h0100, 32'h0, 32'h1_0000, 32'h24_0000});
    pending_steps.push_back('{32'h1_0000, 32'h1_0000, 16'h0100, 32'h1_0000, 32'h1_0000, 32'h0});
    // zero path scale falls back to the thickness
    pending_steps.push_back('{32'h64_0000, 32'h3AA_0000, 16'h0100, 32'h2_0000, 32'h0, 32'h24_0000});
    // all-ones fields
    pending_steps.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF,
                              32'hFFFF_FFFF, 32'hFFFF_FFFF});
    // massless, smallest energy: saturates
    pending_steps.push_back('{32'h1, 32'h0, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1});
    // tiny log argument: correction goes negative
    pending_steps.push_back('{32'h1_0000, 32'h1_0000, 16'h0001, 32'h1, 32'h1, 32'hFFFF_FFFF});
    pending_steps.push_back('{32'h1_0000, 32'h1_0000, 16'h0010, 32'h10, 32'h10, 32'h10_0000});
    // smallest nonzero values everywhere
    pending_steps.push_back('{32'h1, 32'h1, 16'h1, 32'h1, 32'h1, 32'h1});
    pending_steps.push_back('{32'hFFFF_FFFF, 32'h0, 16'h0001, 32'h1, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
    pending_steps.push_back('{32'h1, 32'hFFFF_FFFF, 16'h0100, 32'h1_0000, 32'h1_0000, 32'h1_0000});
    pending_steps.push_back('{32'h0000_0001, 32'hFFFF_FFFF, 16'h0, 32'h0, 32'h0, 32'h0});
    for (int i = 0; i < 500; i++) begin
      st = random_step();
      pending_steps.push_back(st);
    end
  end

  // Reset once, then wait for the stimulus to drain and the pipe to empty.
  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    wait (stimulus_done && expected_angles.size() == 0);
    repeat (300) @(posedge clk);
    if (!failed) begin
      $display("highland_scatter_angle_tb OK");
    end else begin
      $display("highland_scatter_angle_tb NOT OK");
    end
    $finish;
  end

  // Driver: advance on the falling edge, hold each request until it is taken.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || step_taken) begin
        step_taken = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_steps.size() != 0) begin
          in_step <= pending_steps.pop_front();
          in_valid <= 1'b1;
          if (($urandom_range(0, 99)) == 0) no_idle = !no_idle;
          send_gap = no_idle ? 0 : $urandom_range(0, 5);
        end else begin
          in_valid <= 1'b0;
          stimulus_done = 1'b1;
        end
      end
      // Receiver side: stall a random number of cycles per result.
      if (angle_taken) begin
        angle_taken = 1'b0;
        recv_stall = no_idle ? 0 : $urandom_range(0, 5);
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor: predict on every accepted request, check every accepted result.
  always @(posedge clk) begin
    angle_result_t exp_r;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_angles.push_back(highland_angle(in_step));
        step_taken = 1'b1;
      end
      if (out_valid && out_ready) begin
        angle_taken = 1'b1;
        if (expected_angles.size() == 0) begin
          $display("%0t: unexpected result angle=%h status=%0d", $time,
                   scatter_angle, result_status);
          failed = 1'b1;
        end else begin
          exp_r = expected_angles.pop_front();
          if (scatter_angle !== exp_r.angle) begin
            $display("%0t: angle expected %h actual %h", $time, exp_r.angle, scatter_angle);
            failed = 1'b1;
          end
          if (result_status !== exp_r.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_r.status,
                     result_status);
            failed = 1'b1;
          end
        end
      end
    end
  end

  // Watchdog: drop the run if neither channel moves for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("highland_scatter_angle_tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

`default_nettype wire

>>> sim.f
rtl/hsa_pkg.sv
rtl/hsa_stage.sv
rtl/highland_scatter_angle.sv
dv/highland_scatter_angle_tb.sv
